@@ rtl/core/gcrp_pkg.sv @@
// shared types, constants and the group code table for the 4b/5b packer
package gcrp_pkg;

    localparam int ByteW  = 8;
    localparam int NibW   = 4;
    localparam int CodeW  = 5;
    localparam int PhaseW = 2;
    localparam int AccW   = 2 * ByteW;

    localparam logic [NibW-1:0] NibbleMask = 4'b1111;

    typedef enum logic
    {
        REQ_ENCODE = 1'b0,
        REQ_RAW    = 1'b1
    } req_t;

    // one or two finished bytes produced by a single input word
    typedef struct packed
    {
        logic [ByteW-1:0] byte0;
        logic [ByteW-1:0] byte1;
        logic             two;
    } res_t;

    function automatic logic [CodeW-1:0] gcr_code(input logic [NibW-1:0] nib);
        logic [CodeW-1:0] code;
        unique case (nib)
            4'h0: code = 5'h0A;
            4'h1: code = 5'h0B;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h0E;
            4'h5: code = 5'h0F;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h09;
            4'h9: code = 5'h19;
            4'hA: code = 5'h1A;
            4'hB: code = 5'h1B;
            4'hC: code = 5'h0D;
            4'hD: code = 5'h1D;
            4'hE: code = 5'h1E;
            4'hF: code = 5'h15;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/gcrp_pack.sv @@
// bit phase and pending byte state with the combinational packing logic
module gcrp_pack
    import gcrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              item_req,
    input  logic [ByteW-1:0]  item_data,
    input  logic              advance,
    output res_t              res,
    output logic [PhaseW-1:0] phase
);

    logic [PhaseW-1:0]    phase_reg;
    logic [PhaseW-1:0]    phase_next;
    logic [ByteW-1:0]     pending_reg;
    logic [ByteW-1:0]     pending_next;
    logic [PhaseW:0]      held_bits;
    logic [ByteW-1:0]     held_mask;
    logic [ByteW-1:0]     held;
    logic [2*CodeW-1:0]   code10;
    logic [AccW-1:0]      raw_acc;
    logic [AccW-1:0]      enc_acc;
    logic [AccW-1:0]      acc;
    logic                 is_raw;
    logic                 two;

    assign held_bits = {phase_reg, 1'b0};
    // keep only the top 2*phase bits of the pending byte
    assign held_mask = ~(8'hFF >> held_bits);
    assign held      = pending_reg & held_mask;
    assign code10    = {gcr_code(item_data[7:4] & NibbleMask),
                        gcr_code(item_data[3:0] & NibbleMask)};
    assign is_raw    = (item_req == REQ_RAW);

    assign raw_acc = {held, 8'h00}
                   | ({8'h00, item_data} << (4'd8 - {1'b0, held_bits}));
    assign enc_acc = {held, 8'h00}
                   | ({6'h00, code10} << (4'd6 - {1'b0, held_bits}));
    assign acc     = is_raw ? raw_acc : enc_acc;
    assign two     = !is_raw && (phase_reg == 2'd3);

    assign res.byte0 = acc[AccW-1:ByteW];
    assign res.byte1 = acc[ByteW-1:0];
    assign res.two   = two;
    assign phase     = phase_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        if (advance)
        begin
            if (two)
            begin
                phase_next   = '0;
                pending_next = '0;
            end
            else
            begin
                pending_next = acc[ByteW-1:0];
                phase_next   = is_raw ? phase_reg : phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ rtl/core/gcrp_out.sv @@
// result register that hands out one or two bytes per input word
module gcrp_out
    import gcrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  res_t             res_in,
    input  logic             load,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata,   // out_byte[7:0]
    output logic             m_tlast    // last_of_run
);

    logic valid_reg;
    logic valid_next;
    logic idx_reg;
    logic idx_next;
    res_t res_reg;
    logic last;
    logic done;

    assign last     = !res_reg.two || idx_reg;
    assign done     = valid_reg && m_tready && last;
    assign can_load = !valid_reg || done;

    assign m_tvalid = valid_reg;
    assign m_tdata  = idx_reg ? res_reg.byte1 : res_reg.byte0;
    assign m_tlast  = last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 1'b0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
            idx_next   = 1'b0;
        end
        else if (valid_reg && m_tready)
        begin
            idx_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

@@ rtl/core/gcr_four_to_five_bit_packer_core.sv @@
// top level of the 4b/5b group code packer
//
// input stream: s_tdata carries the byte, s_tuser selects the request
// (0 = encode both nibbles through the group code table, 1 = insert raw).
// output stream: m_tdata carries each completed stream byte, msb first;
// m_tlast marks the final byte produced by one input word.
// an encode adds 10 bits and a raw insert 8 bits to the bit stream; a word
// leaves one byte, except an encode at bit phase 3, which leaves two.
// pipeline: input register -> packing logic -> result register, so the
// first byte of a word shows on m_tvalid once the word has moved from
// the input register into the result register.
// throughput: one word per cycle while each word gives one byte and the
// receiver keeps m_tready high; a two-byte word holds the result register
// until both bytes leave, since the output port moves one byte per cycle.
// reset clears the bit phase, the pending byte and all valid flags.
// when the receiver stalls, the result register holds its byte, the input
// register still takes one more word, and s_tready then drops until the
// result register frees up.
module gcr_four_to_five_bit_packer_core
    import gcrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // data_byte[7:0]
    input  logic             s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata,   // out_byte[7:0]
    output logic             m_tlast    // last_of_run
);

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_t              s1_req_reg;
    logic [ByteW-1:0]  s1_data_reg;

    logic              in_take;
    logic              advance;
    logic              can_load;
    res_t              res;
    logic [PhaseW-1:0] phase;

    // a word moves into the result register when that register is free
    assign advance  = s1_valid_reg && can_load;
    assign s_tready = !s1_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_t'(s_tuser);
            s1_data_reg <= s_tdata;
        end
    end

    // packing state and logic
    gcrp_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_req  (s1_req_reg),
        .item_data (s1_data_reg),
        .advance   (advance),
        .res       (res),
        .phase     (phase)
    );

    // result register and byte sequencing
    gcrp_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_in   (res),
        .load     (advance),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a two-byte result only comes from an encode at phase 3
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.two |-> phase == 2'd3 && s1_req_reg == REQ_ENCODE)
        else $error("two-byte result outside phase 3 encode");

    // after a two-byte result is loaded the phase is back at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.two |=> phase == 2'd0)
        else $error("phase not cleared after two-byte result");

    // a non-final byte is always followed by another byte of the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |=> m_tvalid)
        else $error("second byte of a word lost");

    // a held-back input means the input register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && !can_load)
        else $error("input stalled without cause");

endmodule

@@ sim/tb_gcr_four_to_five_bit_packer_core.sv @@
// self-checking testbench for the 4b/5b group code packer core
module tb_gcr_four_to_five_bit_packer_core
    import gcrp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomWords = 1250;
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 20;
    localparam int HoldCycles  = 300;

    // 4b/5b codes for nibbles 0..15, nibble 0 in the lowest 5 bits
    localparam logic [16*CodeW-1:0] GroupCodes = {
        5'h15, 5'h1E, 5'h1D, 5'h0D, 5'h1B, 5'h1A, 5'h19, 5'h09,
        5'h17, 5'h16, 5'h0F, 5'h0E, 5'h13, 5'h12, 5'h0B, 5'h0A
    };

    typedef struct
    {
        req_t             req;
        logic [ByteW-1:0] data;
    } in_word_t;

    typedef struct
    {
        logic [ByteW-1:0] data;
        logic             last;
    } out_byte_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [ByteW-1:0] s_tdata = '0;     // data_byte[7:0]
    logic             s_tuser = 1'b0;   // req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [ByteW-1:0] m_tdata;          // out_byte[7:0]
    logic             m_tlast;          // last_of_run

    in_word_t  tx_words[$];     // words still to be offered
    out_byte_t exp_bytes[$];    // stream bytes still to come, oldest first
    in_word_t  tx_cur;

    // bit stream state as the block should hold it
    logic [PhaseW-1:0] stream_phase;
    logic [ByteW-1:0]  stream_pending;

    int  cycle_count = 0;
    int  words_sent  = 0;
    int  mismatches  = 0;
    int  tx_gap      = 0;
    int  rx_stall    = 0;
    bit  tx_burst    = 1'b0;
    bit  rx_burst    = 1'b0;
    bit  hold_off    = 1'b0;
    bit  timed_out   = 1'b0;

    gcr_four_to_five_bit_packer_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic logic [CodeW-1:0] group_code(input logic [NibW-1:0] nib);
        return GroupCodes[nib*CodeW +: CodeW];
    endfunction

    function automatic void push_byte(input logic [ByteW-1:0] b, input logic last);
        out_byte_t o;
        o.data = b;
        o.last = last;
        exp_bytes.push_back(o);
    endfunction

    // append one accepted word to the bit stream and queue the bytes it completes
    function automatic void pack_stream_word(input in_word_t w);
        int               held_bits;
        logic [ByteW-1:0] held;
        logic [AccW-1:0]  acc;
        logic [9:0]       code;
        held_bits = 2 * int'(stream_phase);
        // only the top held_bits of the pending byte count, stray low bits drop
        held = stream_pending & ~(8'hFF >> held_bits);
        if (w.req == REQ_RAW)
        begin
            acc = {held, 8'h00} | (AccW'(w.data) << (8 - held_bits));
            push_byte(acc[15:8], 1'b1);
            stream_pending = acc[7:0];
        end
        else
        begin
            code = {group_code(w.data[7:4]), group_code(w.data[3:0])};
            acc  = {held, 8'h00} | (AccW'(code) << (6 - held_bits));
            if (stream_phase == 2'd3)
            begin
                // 6 held bits plus 10 code bits fill two whole bytes
                push_byte(acc[15:8], 1'b0);
                push_byte(acc[7:0], 1'b1);
                stream_pending = '0;
                stream_phase   = '0;
            end
            else
            begin
                push_byte(acc[15:8], 1'b1);
                stream_pending = acc[7:0];
                stream_phase   = stream_phase + 2'd1;
            end
        end
    endfunction

    function automatic void queue_word(input req_t req, input logic [ByteW-1:0] data);
        in_word_t w;
        w.req  = req;
        w.data = data;
        tx_words.push_back(w);
    endfunction

    // sender: offers queued words, with a random gap before each new one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_gap   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pack_stream_word(tx_cur);
                words_sent++;
                if ($urandom_range(0, 63) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
            end
            // a word on the bus that was not taken stays as it is
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0 || tx_words.size() == 0)
                begin
                    if (tx_gap > 0)
                        tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    tx_cur = tx_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_cur.data;
                    s_tuser  <= tx_cur.req;
                end
            end
        end
    end

    // receiver: checks each byte taken and stalls at random after it
    always @(posedge clk or negedge rst_n)
    begin
        out_byte_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_bytes.size() == 0)
                    log_mismatch($sformatf("unexpected byte %02h", m_tdata));
                else
                begin
                    e = exp_bytes.pop_front();
                    if (m_tdata !== e.data)
                        log_mismatch($sformatf("byte %02h, want %02h", m_tdata, e.data));
                    if (m_tlast !== e.last)
                        log_mismatch($sformatf("last %b, want %b", m_tlast, e.last));
                end
                if ($urandom_range(0, 63) == 0)
                    rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !hold_off;
        end
    end

    // one long receiver hold-off mid-run so the block backs up into its input
    initial
    begin
        while (words_sent < 400)
            @(negedge clk);
        hold_off = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        stream_phase   = '0;
        stream_pending = '0;

        // all sixteen nibbles, encodes through phases 0..3 twice
        queue_word(REQ_ENCODE, 8'h01);
        queue_word(REQ_ENCODE, 8'h23);
        queue_word(REQ_ENCODE, 8'h45);
        queue_word(REQ_ENCODE, 8'h67);
        queue_word(REQ_ENCODE, 8'h89);
        queue_word(REQ_ENCODE, 8'hAB);
        queue_word(REQ_ENCODE, 8'hCD);
        queue_word(REQ_ENCODE, 8'hEF);
        // raw at phase zero passes straight through
        queue_word(REQ_RAW, 8'h00);
        queue_word(REQ_RAW, 8'hFF);
        // raw inserts at phases 1, 2 and 3
        queue_word(REQ_ENCODE, 8'hFF);
        queue_word(REQ_RAW, 8'hFF);
        queue_word(REQ_ENCODE, 8'h00);
        queue_word(REQ_RAW, 8'hA5);
        queue_word(REQ_ENCODE, 8'h5A);
        queue_word(REQ_RAW, 8'hFF);
        queue_word(REQ_RAW, 8'h00);
        // phase 3 encode gives two bytes, then back to phase zero
        queue_word(REQ_ENCODE, 8'hF0);
        queue_word(REQ_ENCODE, 8'h0F);
        queue_word(REQ_RAW, 8'h3C);

        for (int i = 0; i < RandomWords; i++)
            queue_word(req_t'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while ((tx_words.size() != 0 || s_tvalid || exp_bytes.size() != 0) && !timed_out)
        begin
            @(negedge clk);
            if (cycle_count > CycleLimit)
                timed_out = 1'b1;
        end

        if (timed_out)
            $display("tb: failure");
        else
        begin
            repeat (DrainCycles) @(negedge clk);
            if (exp_bytes.size() != 0)
                log_mismatch($sformatf("%0d bytes never came", exp_bytes.size()));
            if (mismatches == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end
        $finish;
    end

endmodule
